@@ hw/rtl/qenc_pkg.sv @@
// Shared types and constants for the quadrature encoder counter unit.
// Has no dependencies. It is used by qenc_div and quadrature_encoder_counter_unit.
`default_nettype none

package qenc_pkg;

   // Width of the raw transition count.
   localparam int CountWidth = 24;
   // Width of the steps-per-detent register and of the divisor.
   localparam int StepsWidth = 5;
   // Width of a 16-bit detent value times the steps factor.
   localparam int ProdWidth  = 22;
   // Width that holds both a stepped count and a product without overflow.
   localparam int WorkWidth  = (CountWidth + 1 > ProdWidth) ? CountWidth + 1 : ProdWidth;

   // Item opcodes, carried on the request tuser.
   typedef enum logic [1:0] {
      OP_PIN  = 2'd0,
      OP_SET  = 2'd1,
      OP_READ = 2'd2,
      OP_NONE = 2'd3
   } opcode_type;

   // Configuration register indexes (byte address is four times the index).
   typedef enum logic [2:0] {
      REG_STEPS  = 3'd0,
      REG_MIN    = 3'd1,
      REG_MAX    = 3'd2,
      REG_WRAP   = 3'd3,
      REG_COEF   = 3'd4,
      REG_ENABLE = 3'd5
   } reg_index_type;

   // Step directions as 2-bit signed codes.
   localparam logic signed [1:0] DirNone = 2'sb00;
   localparam logic signed [1:0] DirUp   = 2'sb01;
   localparam logic signed [1:0] DirDown = 2'sb11;

   // Quadrature transition table, indexed by {previous B, previous A, B, A}.
   localparam logic signed [1:0] StepTable [16] = '{
      DirNone, DirDown, DirUp,   DirNone,
      DirUp,   DirNone, DirNone, DirDown,
      DirDown, DirNone, DirNone, DirUp,
      DirNone, DirUp,   DirDown, DirNone
   };

   // Result of the serial divider.
   typedef struct packed {
      logic                  done;
      logic [CountWidth-1:0] quotient;
      logic [StepsWidth-1:0] remainder;
   } div_result_type;

endpackage

`default_nettype wire

@@ hw/rtl/qenc_div.sv @@
// Bit-serial restoring divider for the count magnitude by the steps factor.
// Depends on qenc_pkg for widths and the result struct.
`default_nettype none

module qenc_div
   import qenc_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire logic [CountWidth-1:0] dividend,
   input  wire logic [StepsWidth-1:0] divisor,
   output div_result_type             result
);

   localparam int CntBits = $clog2(CountWidth);

   logic [CountWidth-1:0] acc_ff, acc_in;
   logic [StepsWidth-1:0] rem_ff, rem_in;
   logic [CntBits-1:0]    cnt_ff, cnt_in;
   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [StepsWidth:0]   trial;
   logic [StepsWidth:0]   diff;
   logic                  fits;

   // One quotient bit per cycle: shift the next dividend bit into the remainder.
   always_comb begin
      trial   = {rem_ff, acc_ff[CountWidth-1]};
      diff    = trial - {1'b0, divisor};
      fits    = trial >= {1'b0, divisor};
      acc_in  = acc_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         acc_in  = dividend;
         rem_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         acc_in = {acc_ff[CountWidth-2:0], fits};
         rem_in = fits ? diff[StepsWidth-1:0] : trial[StepsWidth-1:0];
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CntBits'(CountWidth - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign result.done      = done_ff;
   assign result.quotient  = acc_ff;
   assign result.remainder = rem_ff;

endmodule

`default_nettype wire

@@ hw/rtl/quadrature_encoder_counter_unit.sv @@
// Top level of the quadrature encoder counter: APB register file, item sequencer.
// Depends on qenc_pkg and on the serial divider qenc_div.
//
// The unit takes one request beat at a time and returns one response beat for it.
// Every item waits on the bit-serial divider, which works through the 24-bit count
// magnitude one bit at a time; a pin sample that moves the count divides twice,
// once to find whether the step crosses a detent boundary and once to report the
// new position. A new request is taken as soon as the previous response sits in
// the output register, even while that response still waits for the consumer.
// Configuration registers are read back at any time and are to be written over the
// APB port only while the unit is idle; the unit itself does not enforce this.
`default_nettype none

module quadrature_encoder_counter_unit
   import qenc_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   // Request stream
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // [0] pin_a, [1] pin_b, [33:2] time_ms, [49:34] new_value, [55:50] zero
   input  wire logic [55:0] req_tdata,
   // [1:0] opcode
   input  wire logic [1:0]  req_tuser,
   // Response stream
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // [15:0] position, [17:16] change, [23:18] zero
   output logic [23:0]      rsp_tdata,
   // Configuration port
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [4:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   localparam logic [31:0] AccelWindow = 32'd200;
   localparam logic [7:0]  AccelFloor  = 8'd4;
   localparam logic signed [WorkWidth-1:0] CountMax =
      WorkWidth'((64'sd1 <<< (CountWidth - 1)) - 64'sd1);
   localparam logic signed [WorkWidth-1:0] CountMin = -CountMax - WorkWidth'(1);

   typedef enum logic [3:0] {
      S_IDLE,
      S_LIM_LO,
      S_LIM_HI,
      S_MUL_SET,
      S_PRE_GO,
      S_PRE_WAIT,
      S_STEP,
      S_APPLY,
      S_OUT_GO,
      S_OUT_WAIT,
      S_FINISH
   } state_type;

   // Saturate a work-width value to the signed count range.
   function automatic logic signed [CountWidth-1:0] sat_count(
      input logic signed [WorkWidth-1:0] x
   );
      logic signed [WorkWidth-1:0] y;
      y = x;
      if (x > CountMax) y = CountMax;
      if (x < CountMin) y = CountMin;
      return y[CountWidth-1:0];
   endfunction

   // ------------------------------------------------------------------
   // Configuration registers
   // ------------------------------------------------------------------
   logic [StepsWidth-1:0] cfg_steps_ff;
   logic signed [15:0]    cfg_min_ff;
   logic signed [15:0]    cfg_max_ff;
   logic                  cfg_wrap_ff;
   logic [11:0]           cfg_coef_ff;
   logic                  cfg_enabled_ff;
   logic                  csr_write;
   reg_index_type         csr_index;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = reg_index_type'(csr_paddr[4:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_steps_ff   <= StepsWidth'(4);
         cfg_min_ff     <= -16'sd32768;
         cfg_max_ff     <= 16'sd32767;
         cfg_wrap_ff    <= 1'b0;
         cfg_coef_ff    <= '0;
         cfg_enabled_ff <= 1'b0;
      end else if (csr_write) begin
         case (csr_index)
            REG_STEPS:  cfg_steps_ff   <= csr_pwdata[StepsWidth-1:0];
            REG_MIN:    cfg_min_ff     <= csr_pwdata[15:0];
            REG_MAX:    cfg_max_ff     <= csr_pwdata[15:0];
            REG_WRAP:   cfg_wrap_ff    <= csr_pwdata[0];
            REG_COEF:   cfg_coef_ff    <= csr_pwdata[11:0];
            REG_ENABLE: cfg_enabled_ff <= csr_pwdata[0];
            default: ;
         endcase
      end
   end

   // Register read-back.
   always_comb begin
      case (csr_index)
         REG_STEPS:  csr_prdata = {{(32 - StepsWidth){1'b0}}, cfg_steps_ff};
         REG_MIN:    csr_prdata = 32'(cfg_min_ff);
         REG_MAX:    csr_prdata = 32'(cfg_max_ff);
         REG_WRAP:   csr_prdata = {31'b0, cfg_wrap_ff};
         REG_COEF:   csr_prdata = {20'b0, cfg_coef_ff};
         REG_ENABLE: csr_prdata = {31'b0, cfg_enabled_ff};
         default:    csr_prdata = '0;
      endcase
   end

   // Steps factor used by the arithmetic: zero acts as one, above 16 as 16.
   logic [StepsWidth-1:0] steps_eff;
   always_comb begin
      steps_eff = cfg_steps_ff;
      if (cfg_steps_ff == '0) steps_eff = StepsWidth'(1);
      if (cfg_steps_ff > StepsWidth'(16)) steps_eff = StepsWidth'(16);
   end

   // ------------------------------------------------------------------
   // Sequencer state and item registers
   // ------------------------------------------------------------------
   state_type                    state_ff, state_in;
   opcode_type                   op_ff, op_in;
   logic [31:0]                  time_ff, time_in;
   logic signed [15:0]           nv_ff, nv_in;
   logic signed [1:0]            dir_ff, dir_in;
   logic [1:0]                   prev_ff, prev_in;
   logic signed [CountWidth-1:0] raw_ff, raw_in;
   logic signed [15:0]           last_read_ff, last_read_in;
   logic [31:0]                  last_time_ff, last_time_in;
   logic signed [1:0]            last_dir_ff, last_dir_in;
   logic signed [CountWidth-1:0] lo_ff, lo_in;
   logic signed [CountWidth-1:0] hi_ff, hi_in;
   logic signed [WorkWidth-1:0]  v_ff, v_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic signed [15:0]           rsp_pos_ff, rsp_pos_in;
   logic signed [1:0]            rsp_chg_ff, rsp_chg_in;

   // Shared multiplier: bound or new value times the steps factor.
   logic signed [ProdWidth-1:0] mul_a;
   logic signed [ProdWidth-1:0] mul_b;
   logic signed [ProdWidth-1:0] prod;

   always_comb begin
      case (state_ff)
         S_LIM_LO: mul_a = ProdWidth'(cfg_min_ff);
         S_LIM_HI: mul_a = ProdWidth'(cfg_max_ff);
         default:  mul_a = ProdWidth'(nv_ff);
      endcase
      mul_b = ProdWidth'($signed({1'b0, steps_eff}));
      prod  = mul_a * mul_b;
   end

   // Serial divider on the count magnitude.
   logic                  div_start;
   logic [CountWidth-1:0] raw_mag;
   div_result_type        div_res;

   assign div_start = (state_ff == S_PRE_GO) || (state_ff == S_OUT_GO);
   assign raw_mag   = raw_ff[CountWidth-1] ? CountWidth'(-raw_ff) : CountWidth'(raw_ff);

   qenc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (raw_mag),
      .divisor  (steps_eff),
      .result   (div_res)
   );

   // Boundary crossing: a step away from zero crosses when the remainder is
   // one short of the steps factor, a step toward zero when the remainder is zero.
   logic        raw_zero;
   logic        raw_neg;
   logic        dir_up;
   logic        away;
   logic        crossing;
   logic [31:0] dt;
   logic [7:0]  dt_floor;
   logic        accel_hit;

   always_comb begin
      raw_zero  = raw_ff == '0;
      raw_neg   = raw_ff[CountWidth-1];
      dir_up    = dir_ff == DirUp;
      away      = raw_zero || (raw_neg != dir_up);
      crossing  = away ? (div_res.remainder == steps_eff - 1'b1)
                       : (div_res.remainder == '0);
      dt        = time_ff - last_time_ff;
      dt_floor  = (dt < 32'(AccelFloor)) ? AccelFloor : dt[7:0];
      accel_hit = (dir_ff == last_dir_ff) && (dt < AccelWindow)
                  && (cfg_coef_ff >= {4'b0, dt_floor});
   end

   // Clamp or wrap the stepped value against the raw bounds.
   logic signed [WorkWidth-1:0] lim_v;
   always_comb begin
      lim_v = v_ff;
      if (lim_v > WorkWidth'(hi_ff)) lim_v = cfg_wrap_ff ? WorkWidth'(lo_ff) : WorkWidth'(hi_ff);
      if (lim_v < WorkWidth'(lo_ff)) lim_v = cfg_wrap_ff ? WorkWidth'(hi_ff) : WorkWidth'(lo_ff);
   end

   // Detent value from the quotient, saturated to 16 bits, and the read change.
   logic signed [15:0] detent;
   logic signed [16:0] read_diff;
   logic signed [1:0]  read_chg;

   always_comb begin
      if (raw_neg) begin
         detent = (div_res.quotient > CountWidth'(32768)) ? -16'sd32768
                  : 16'(-div_res.quotient);
      end else begin
         detent = (div_res.quotient > CountWidth'(32767)) ? 16'sd32767
                  : div_res.quotient[15:0];
      end
      read_diff = 17'(detent) - 17'(last_read_ff);
      if (read_diff > 17'sd1) read_chg = 2'sb01;
      else if (read_diff < -17'sd1) read_chg = 2'sb11;
      else read_chg = read_diff[1:0];
   end

   // Next-state logic.
   logic signed [1:0]           pin_dir;
   logic signed [2:0]           step_delta;
   logic                        slot_free;

   always_comb begin
      pin_dir      = StepTable[{prev_ff, req_tdata[1], req_tdata[0]}];
      slot_free    = !rsp_valid_ff || rsp_tready;
      step_delta   = 3'(dir_ff);
      state_in     = state_ff;
      op_in        = op_ff;
      time_in      = time_ff;
      nv_in        = nv_ff;
      dir_in       = dir_ff;
      prev_in      = prev_ff;
      raw_in       = raw_ff;
      last_read_in = last_read_ff;
      last_time_in = last_time_ff;
      last_dir_in  = last_dir_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      v_in         = v_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_pos_in   = rsp_pos_ff;
      rsp_chg_in   = rsp_chg_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               op_in    = opcode_type'(req_tuser);
               time_in  = req_tdata[33:2];
               nv_in    = req_tdata[49:34];
               dir_in   = pin_dir;
               state_in = S_OUT_GO;
               case (opcode_type'(req_tuser))
                  OP_PIN: begin
                     if (cfg_enabled_ff) begin
                        prev_in = req_tdata[1:0] ;
                        if (pin_dir != DirNone) state_in = S_LIM_LO;
                     end
                  end
                  OP_SET:  state_in = S_LIM_LO;
                  default: state_in = S_OUT_GO;
               endcase
            end
         end
         S_LIM_LO: begin
            lo_in    = sat_count(WorkWidth'(prod));
            state_in = S_LIM_HI;
         end
         S_LIM_HI: begin
            hi_in    = sat_count(WorkWidth'(prod));
            state_in = (op_ff == OP_SET) ? S_MUL_SET : S_PRE_GO;
         end
         S_MUL_SET: begin
            v_in         = WorkWidth'(prod);
            last_read_in = nv_ff;
            state_in     = S_APPLY;
         end
         S_PRE_GO: state_in = S_PRE_WAIT;
         S_PRE_WAIT: begin
            if (div_res.done) state_in = S_STEP;
         end
         S_STEP: begin
            if (crossing && (cfg_coef_ff > 12'd1)) begin
               if (accel_hit) step_delta = 3'(dir_ff) + 3'(dir_ff);
               last_time_in = time_ff;
               last_dir_in  = dir_ff;
            end
            v_in     = WorkWidth'(raw_ff) + WorkWidth'(step_delta);
            state_in = S_APPLY;
         end
         S_APPLY: begin
            raw_in   = lim_v[CountWidth-1:0];
            state_in = S_OUT_GO;
         end
         S_OUT_GO: state_in = S_OUT_WAIT;
         S_OUT_WAIT: begin
            if (div_res.done) state_in = S_FINISH;
         end
         S_FINISH: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_pos_in   = detent;
               rsp_chg_in   = 2'sb00;
               if (op_ff == OP_READ) begin
                  rsp_chg_in   = read_chg;
                  last_read_in = detent;
               end
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // State, count state and registered response.
   always_ff @(posedge clock) begin
      op_ff      <= op_in;
      time_ff    <= time_in;
      nv_ff      <= nv_in;
      dir_ff     <= dir_in;
      lo_ff      <= lo_in;
      hi_ff      <= hi_in;
      v_ff       <= v_in;
      rsp_pos_ff <= rsp_pos_in;
      rsp_chg_ff <= rsp_chg_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         prev_ff      <= '0;
         raw_ff       <= '0;
         last_read_ff <= '0;
         last_time_ff <= '0;
         last_dir_ff  <= DirNone;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         prev_ff      <= prev_in;
         raw_ff       <= raw_in;
         last_read_ff <= last_read_in;
         last_time_ff <= last_time_in;
         last_dir_ff  <= last_dir_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_tready = state_ff == S_IDLE;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b0, rsp_chg_ff, rsp_pos_ff};

endmodule

`default_nettype wire

@@ test/qenc_checker.sv @@
// Checker for the quadrature encoder counter unit: mirrors the register writes,
// predicts one response beat per request beat and compares them in order.
// Depends on qenc_pkg for the opcode and register index types.
`timescale 1ns / 100ps

module qenc_checker
   import qenc_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   input  wire logic        req_tready,
   // [0] pin_a, [1] pin_b, [33:2] time_ms, [49:34] new_value, [55:50] zero
   input  wire logic [55:0] req_tdata,
   // [1:0] opcode
   input  wire logic [1:0]  req_tuser,
   input  wire logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   // [15:0] position, [17:16] change, [23:18] zero
   input  wire logic [23:0] rsp_tdata,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [4:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   input  wire logic        csr_pready,
   output int               mismatch_count,
   output int               outstanding
);

   typedef struct {
      logic signed [15:0] position;
      logic signed [1:0]  change;
   } reading_type;

   localparam longint CountMax = (longint'(1) << (CountWidth - 1)) - 1;

   // Readings predicted for request beats whose response has not arrived yet.
   reading_type due_readings[$];
   int          fault_tally = 0;

   // Mirror of the configuration registers.
   logic [4:0]  steps_reg;
   longint      floor_reg;
   longint      ceiling_reg;
   logic        wrap_reg;
   logic [11:0] coef_reg;
   logic        enable_reg;

   // Mirror of the counter state.
   logic [1:0]  pins_seen;
   longint      raw_tally;
   longint      read_mark;
   logic [31:0] move_stamp;
   int          move_dir;

   function automatic longint clip(input longint v, input longint lo, input longint hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
   endfunction

   // Out-of-range step settings are pulled into 1..16.
   function automatic longint divisor();
      return clip(longint'(steps_reg), 1, 16);
   endfunction

   // Clamp or wrap a raw count against the bounds scaled to raw transitions.
   // The upper bound is tested first, so crossed bounds clamp onto the lower one.
   function automatic longint bound_tally(input longint v);
      longint lo;
      longint hi;
      lo = clip(floor_reg * divisor(), -CountMax - 1, CountMax);
      hi = clip(ceiling_reg * divisor(), -CountMax - 1, CountMax);
      if (v > hi) v = wrap_reg ? lo : hi;
      if (v < lo) v = wrap_reg ? hi : lo;
      return clip(v, -CountMax - 1, CountMax);
   endfunction

   function automatic longint detents();
      return clip(raw_tally / divisor(), -32768, 32767);
   endfunction

   // Place of a B:A pin pair along the forward Gray sequence 00, 10, 11, 01.
   function automatic int gray_phase(input logic [1:0] pins);
      case (pins)
         2'b00:   return 0;
         2'b10:   return 1;
         2'b11:   return 2;
         default: return 3;
      endcase
   endfunction

   // One place forward counts up, one place back counts down; no move or a
   // jump of two places counts nothing.
   function automatic int quad_dir(input logic [1:0] from, input logic [1:0] to);
      int d;
      d = (gray_phase(to) - gray_phase(from) + 4) % 4;
      if (d == 1) return 1;
      if (d == 3) return -1;
      return 0;
   endfunction

   // Apply one request beat to the mirrored state and queue the reading it yields.
   task automatic advance_encoder(input opcode_type op, input logic [1:0] pins,
                                  input logic [31:0] now, input logic signed [15:0] target);
      int          dir;
      longint      v;
      longint      mark;
      longint      d;
      int unsigned gap;
      reading_type r;
      r.change = 2'sb00;
      case (op)
         OP_PIN: begin
            if (enable_reg) begin
               dir = quad_dir(pins_seen, pins);
               pins_seen = pins;
               if (dir != 0) begin
                  mark = raw_tally / divisor();
                  v = raw_tally + dir;
                  // Acceleration is judged only when a detent boundary is crossed.
                  if (v / divisor() != mark && coef_reg > 1) begin
                     if (dir == move_dir) begin
                        gap = now - move_stamp;
                        if (gap < 200) begin
                           if (gap < 4) gap = 4;
                           if (coef_reg / gap >= 1) v += dir;
                        end
                     end
                     move_stamp = now;
                     move_dir = dir;
                  end
                  raw_tally = bound_tally(v);
               end
            end
         end
         OP_SET: begin
            raw_tally = bound_tally(longint'(target) * divisor());
            read_mark = target;
         end
         OP_READ: begin
            d = detents();
            r.change = 2'(clip(d - read_mark, -1, 1));
            read_mark = d;
         end
         default: ;
      endcase
      r.position = 16'(detents());
      due_readings.push_back(r);
   endtask

   task automatic store_register(input logic [2:0] index, input logic [31:0] value);
      case (reg_index_type'(index))
         REG_STEPS:  steps_reg = value[4:0];
         REG_MIN:    floor_reg = longint'($signed(value[15:0]));
         REG_MAX:    ceiling_reg = longint'($signed(value[15:0]));
         REG_WRAP:   wrap_reg = value[0];
         REG_COEF:   coef_reg = value[11:0];
         REG_ENABLE: enable_reg = value[0];
         default: ;
      endcase
   endtask

   // Response beats are matched before request beats of the same edge, so a
   // stray response can never pair with an expectation made at that edge.
   always @(posedge clock) begin
      reading_type want;
      if (reset) begin
         steps_reg = 5'd4;
         floor_reg = -32768;
         ceiling_reg = 32767;
         wrap_reg = 1'b0;
         coef_reg = 12'd0;
         enable_reg = 1'b0;
         pins_seen = 2'b00;
         raw_tally = 0;
         read_mark = 0;
         move_stamp = 32'd0;
         move_dir = 0;
         due_readings.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (due_readings.size() == 0) begin
               $display("%0t: response beat with nothing expected, position %0d change %0d",
                        $time, $signed(rsp_tdata[15:0]), $signed(rsp_tdata[17:16]));
               fault_tally++;
            end else begin
               want = due_readings.pop_front();
               if (rsp_tdata[15:0] !== want.position) begin
                  $display("%0t: position expected %0d, got %0d",
                           $time, want.position, $signed(rsp_tdata[15:0]));
                  fault_tally++;
               end
               if (rsp_tdata[17:16] !== want.change) begin
                  $display("%0t: change expected %0d, got %0d",
                           $time, want.change, $signed(rsp_tdata[17:16]));
                  fault_tally++;
               end
            end
         end
         if (req_tvalid && req_tready)
            advance_encoder(opcode_type'(req_tuser), req_tdata[1:0], req_tdata[33:2],
                            req_tdata[49:34]);
         if (csr_psel && csr_penable && csr_pwrite && csr_pready)
            store_register(csr_paddr[4:2], csr_pwdata);
      end
      mismatch_count <= fault_tally;
      outstanding <= due_readings.size();
   end

endmodule

@@ test/quadrature_encoder_counter_unit_tb.sv @@
// Testbench top for the quadrature encoder counter unit: clock, reset, request and
// register stimulus, random back-pressure and the verdict.
// Depends on qenc_pkg, the unit itself and the qenc_checker module.
`timescale 1ns / 100ps

module quadrature_encoder_counter_unit_tb
   import qenc_pkg::*;
();

   localparam int CycleLimit    = 800000;
   localparam int RandomPhases  = 10;
   localparam int ItemsPerPhase = 122;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [55:0] req_tdata;
   logic [1:0]  req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [23:0] rsp_tdata;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [4:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   int mismatch_count;
   int outstanding;
   int cycle_count;

   // Idle and stall odds in percent, set per phase.
   int src_idle;
   int sink_stall;

   // Shaft model used to build well-formed pin sequences.
   logic [1:0]  shaft_pins;
   logic [31:0] clock_ms;
   bit          spin;

   quadrature_encoder_counter_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   qenc_checker checker_unit (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_pready     (csr_pready),
      .mismatch_count (mismatch_count),
      .outstanding    (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Watchdog on the total run length.
   initial begin
      cycle_count = 0;
      while (cycle_count < CycleLimit) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("** quadrature_encoder_counter_unit: FAILED **");
      $finish;
   end

   // Response consumer with random stalls.
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_tready = ($urandom_range(99) >= sink_stall);
      end
   end

   // Next pin pair along the Gray sequence 00, 10, 11, 01 (B:A), forward or back.
   function automatic logic [1:0] gray_next(input logic [1:0] p, input bit up);
      case (p)
         2'b00:   return up ? 2'b10 : 2'b01;
         2'b10:   return up ? 2'b11 : 2'b00;
         2'b11:   return up ? 2'b01 : 2'b10;
         default: return up ? 2'b00 : 2'b11;
      endcase
   endfunction

   // Hold off until every expected response has come back and the unit is idle.
   task automatic wait_drain();
      while (outstanding != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic csr_write(input reg_index_type index, input logic [31:0] value);
      wait_drain();
      csr_psel = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite = 1'b1;
      csr_paddr = {index, 2'b00};
      csr_pwdata = value;
      @(negedge clock);
      csr_penable = 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      @(negedge clock);
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
   endtask

   // Present one request beat, after a random idle gap, and wait for it to be taken.
   task automatic send_item(input opcode_type op, input logic [1:0] pins,
                            input logic [31:0] stamp, input logic [15:0] value);
      while ($urandom_range(99) < src_idle) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser = op;
      req_tdata = {6'd0, value, stamp, pins};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
      req_tvalid = 1'b0;
   endtask

   // Turn the shaft by a number of transitions, stride_ms apart.
   task automatic turn(input bit up, input int count, input int unsigned stride_ms);
      repeat (count) begin
         shaft_pins = gray_next(shaft_pins, up);
         clock_ms += stride_ms;
         send_item(OP_PIN, shaft_pins, clock_ms, 16'($urandom));
      end
   endtask

   // Mostly steady rotation with occasional reversals, glitches and time jumps;
   // the rest are set, read and unused items with random content.
   task automatic random_item();
      int          pick;
      logic [1:0]  pins;
      logic [15:0] value;
      logic [31:0] stamp;
      pick = $urandom_range(99);
      pins = 2'($urandom);
      value = 16'($urandom);
      stamp = $urandom;
      if (pick < 70) begin
         if ($urandom_range(99) < 8) spin = !spin;
         if ($urandom_range(99) < 5) shaft_pins = pins;
         else shaft_pins = gray_next(shaft_pins, spin);
         pick = $urandom_range(99);
         if (pick < 85) clock_ms += $urandom_range(0, 60);
         else if (pick < 97) clock_ms += $urandom_range(100, 400);
         else clock_ms = $urandom;
         send_item(OP_PIN, shaft_pins, clock_ms, value);
      end else if (pick < 80) begin
         if ($urandom_range(1) == 1) value = 16'($urandom_range(0, 12) - 6);
         send_item(OP_SET, pins, stamp, value);
      end else if (pick < 96) begin
         send_item(OP_READ, pins, stamp, value);
      end else begin
         send_item(OP_NONE, pins, stamp, value);
      end
   endtask

   // New register settings for a random phase; narrow bounds are favored so
   // that clamping and wrapping happen often.
   task automatic pick_config();
      int pick;
      int lo;
      int hi;
      case ($urandom_range(5))
         0:       csr_write(REG_STEPS, 32'd1);
         1:       csr_write(REG_STEPS, 32'd2);
         2:       csr_write(REG_STEPS, 32'd4);
         3:       csr_write(REG_STEPS, 32'd16);
         default: csr_write(REG_STEPS, $urandom_range(31));
      endcase
      pick = $urandom_range(9);
      if (pick < 5) begin
         lo = -int'($urandom_range(0, 6));
         hi = $urandom_range(0, 6);
      end else if (pick < 7) begin
         lo = $urandom_range(1, 4);
         hi = -int'($urandom_range(0, 4));
      end else if (pick < 9) begin
         lo = -32768;
         hi = 32767;
      end else begin
         lo = int'(shortint'($urandom));
         hi = int'(shortint'($urandom));
      end
      csr_write(REG_MIN, lo);
      csr_write(REG_MAX, hi);
      csr_write(REG_WRAP, $urandom_range(1));
      case ($urandom_range(5))
         0:       csr_write(REG_COEF, 32'd0);
         1:       csr_write(REG_COEF, 32'd1);
         2:       csr_write(REG_COEF, 32'd2);
         3:       csr_write(REG_COEF, 32'd4095);
         4:       csr_write(REG_COEF, $urandom_range(3, 300));
         default: csr_write(REG_COEF, $urandom_range(4095));
      endcase
      csr_write(REG_ENABLE, 32'($urandom_range(9) != 0));
   endtask

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = OP_PIN;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      src_idle = 0;
      sink_stall = 0;
      shaft_pins = 2'b00;
      clock_ms = 32'd0;
      spin = 1'b1;
      repeat (10) @(negedge clock);
      reset = 1'b0;

      // Counting is off after reset: a pin sample must leave everything alone.
      send_item(OP_PIN, 2'b10, 32'd10, 16'h0000);
      send_item(OP_NONE, 2'b11, 32'hffff_ffff, 16'hffff);
      send_item(OP_READ, 2'b00, 32'd0, 16'h0000);

      // One detent forward and back at four transitions per detent, then a
      // two-place jump that must not count.
      csr_write(REG_ENABLE, 32'd1);
      clock_ms = 32'd20;
      turn(1'b1, 4, 10);
      send_item(OP_READ, 2'b00, 32'd0, 16'h0000);
      turn(1'b0, 4, 10);
      shaft_pins = 2'b11;
      send_item(OP_PIN, shaft_pins, clock_ms, 16'h0000);
      send_item(OP_READ, 2'b00, 32'd0, 16'h0000);

      // Set to both ends of the detent range.
      send_item(OP_SET, 2'b00, 32'd0, 16'h7fff);
      send_item(OP_SET, 2'b00, 32'd0, 16'h8000);

      // Fast turns with full acceleration, across the wrap of the millisecond
      // counter and with intervals under the 4 ms floor.
      csr_write(REG_STEPS, 32'd1);
      csr_write(REG_COEF, 32'd4095);
      clock_ms = 32'hffff_fff8;
      turn(1'b1, 4, 3);
      send_item(OP_READ, 2'b00, 32'd0, 16'h0000);

      // Wrap from each bound to the opposite one.
      csr_write(REG_COEF, 32'd0);
      csr_write(REG_MIN, -32'sd2);
      csr_write(REG_MAX, 32'd2);
      csr_write(REG_WRAP, 32'd1);
      send_item(OP_SET, 2'b00, 32'd0, 16'd2);
      turn(1'b1, 1, 10);
      turn(1'b0, 1, 10);

      // Lower bound above the upper one.
      csr_write(REG_WRAP, 32'd0);
      csr_write(REG_MIN, 32'd3);
      csr_write(REG_MAX, -32'sd3);
      send_item(OP_SET, 2'b00, 32'd0, 16'd0);
      send_item(OP_READ, 2'b00, 32'd0, 16'h0000);

      // Large count left behind by a steps change saturates the position;
      // steps of zero and above sixteen are pulled into range.
      csr_write(REG_STEPS, 32'd16);
      csr_write(REG_MIN, -32'sd32768);
      csr_write(REG_MAX, 32'd32767);
      send_item(OP_SET, 2'b00, 32'd0, 16'h7fff);
      csr_write(REG_STEPS, 32'd1);
      send_item(OP_READ, 2'b00, 32'd0, 16'h0000);
      csr_write(REG_STEPS, 32'd31);
      send_item(OP_READ, 2'b00, 32'd0, 16'h0000);
      csr_write(REG_STEPS, 32'd0);
      send_item(OP_READ, 2'b00, 32'd0, 16'h0000);

      // Random phases cycling through the idle and stall patterns.
      for (int phase = 0; phase < RandomPhases; phase++) begin
         case (phase % 4)
            0: begin src_idle = 0;  sink_stall = 0;  end
            1: begin src_idle = 48; sink_stall = 0;  end
            2: begin src_idle = 0;  sink_stall = 48; end
            default: begin src_idle = 16; sink_stall = 16; end
         endcase
         pick_config();
         for (int i = 0; i < ItemsPerPhase; i++) begin
            // Let the unit run dry once per phase.
            if (i == ItemsPerPhase / 2) wait_drain();
            random_item();
         end
      end

      wait_drain();
      repeat (80) @(negedge clock);
      if (mismatch_count == 0 && outstanding == 0)
         $display("** quadrature_encoder_counter_unit: PASSED **");
      else
         $display("** quadrature_encoder_counter_unit: FAILED **");
      $finish;
   end

endmodule
